>>> sv/hcbd_pkg.sv
// shared types, codes and character helpers for the chunked body deframer
`default_nettype none

package hcbd_pkg;

  localparam int SIZE_BITS_DEFAULT = 32;
  localparam int LEN_BITS = 12;
  localparam logic [LEN_BITS-1:0] MAX_LINE_RESET = 12'd255;

  // parse modes
  localparam logic [2:0] MODE_SIZE    = 3'd0;
  localparam logic [2:0] MODE_EXT     = 3'd1;
  localparam logic [2:0] MODE_JUNK    = 3'd2;
  localparam logic [2:0] MODE_OVF     = 3'd3;
  localparam logic [2:0] MODE_DATA    = 3'd4;
  localparam logic [2:0] MODE_TRAILER = 3'd5;
  localparam logic [2:0] MODE_DONE    = 3'd6;
  localparam logic [2:0] MODE_ERROR   = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_SIZE_OVF  = 2'd0;
  localparam logic [1:0] ERR_LINE_LONG = 2'd1;
  localparam logic [1:0] ERR_END_HDR   = 2'd2;
  localparam logic [1:0] ERR_END_DATA  = 2'd3;

  // characters
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
  } result_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/hcbd_core.sv
// parser state and per-byte next-state logic of the chunked body deframer
`default_nettype none

module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_stream,
  input  wire logic [LEN_BITS-1:0] max_line_length,
  output result_t                  res
);

  typedef struct packed {
    logic                 ok;
    logic [2:0]           mode;
    logic [SIZE_BITS-1:0] acc;
    logic [LEN_BITS-1:0]  len;
    logic                 digit;
  } line_t;

  logic [2:0]           mode, mode_next;
  logic [SIZE_BITS-1:0] remaining, remaining_next;
  logic [SIZE_BITS-1:0] acc, acc_next;
  logic [LEN_BITS-1:0]  line_len, line_len_next;
  logic                 digit_seen, digit_seen_next;
  logic                 pending_cr, pending_cr_next;
  logic [1:0]           err_code, err_code_next;

  line_t cur, f1, f2;

  // one line character; ok low means the line got too long
  function automatic line_t feed(input line_t s, input logic [7:0] c,
                                 input logic [LEN_BITS-1:0] maxl);
    line_t      r;
    logic [4:0] hv;
    r = s;
    r.ok = 1'b1;
    hv = hex_value(c);
    if (s.len >= maxl) begin
      r.ok = 1'b0;
    end else begin
      r.len = s.len + LEN_BITS'(1);
      if (s.mode == MODE_SIZE) begin
        if (!hv[4]) begin
          if (s.acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.mode = MODE_OVF;
          end else begin
            r.acc = {s.acc[SIZE_BITS-5:0], hv[3:0]};
            r.digit = 1'b1;
          end
        end else if (!s.digit) begin
          if (c != CH_SP && c != CH_TAB) r.mode = MODE_JUNK;
        end else begin
          r.mode = (c == CH_SEMI) ? MODE_EXT : MODE_JUNK;
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    cur = '{ok: 1'b1, mode: mode, acc: acc, len: line_len, digit: digit_seen};
    f1 = pending_cr ? feed(cur, CH_CR, max_line_length) : cur;
    f2 = feed(f1, in_byte, max_line_length);
  end

  always_comb begin
    mode_next       = mode;
    remaining_next  = remaining;
    acc_next        = acc;
    line_len_next   = line_len;
    digit_seen_next = digit_seen;
    pending_cr_next = pending_cr;
    err_code_next   = err_code;
    res             = '0;
    if (step) begin
      if (mode == MODE_ERROR) begin
        res = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: err_code};
      end else if (mode == MODE_DONE) begin
        res = '0;
      end else if (end_of_stream) begin
        mode_next = MODE_ERROR;
        err_code_next = (mode == MODE_DATA) ? ERR_END_DATA : ERR_END_HDR;
        res = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: err_code_next};
      end else if (mode == MODE_DATA) begin
        remaining_next = remaining - SIZE_BITS'(1);
        if (remaining == SIZE_BITS'(1)) begin
          mode_next       = MODE_SIZE;
          acc_next        = '0;
          line_len_next   = '0;
          digit_seen_next = 1'b0;
          pending_cr_next = 1'b0;
        end
        res = '{valid: 1'b1, kind: KIND_DATA, data: in_byte, code: 2'd0};
      end else if (in_byte == CH_LF) begin
        // end of line: clear it, then decide what the line meant
        acc_next        = '0;
        line_len_next   = '0;
        digit_seen_next = 1'b0;
        pending_cr_next = 1'b0;
        unique case (mode)
          MODE_SIZE, MODE_EXT: begin
            if (mode == MODE_EXT || digit_seen) begin
              if (acc == '0) begin
                mode_next = MODE_TRAILER;
              end else begin
                mode_next = MODE_DATA;
                remaining_next = acc;
              end
            end
          end
          MODE_JUNK: mode_next = MODE_SIZE;
          MODE_OVF: begin
            mode_next = MODE_ERROR;
            err_code_next = ERR_SIZE_OVF;
            res = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: ERR_SIZE_OVF};
          end
          MODE_TRAILER: begin
            if (line_len == '0) begin
              mode_next = MODE_DONE;
              res = '{valid: 1'b1, kind: KIND_END, data: 8'd0, code: 2'd0};
            end
          end
          default: mode_next = mode;
        endcase
      end else if (!f1.ok || (in_byte != CH_CR && !f2.ok)) begin
        mode_next = MODE_ERROR;
        err_code_next = ERR_LINE_LONG;
        res = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0, code: ERR_LINE_LONG};
      end else if (in_byte == CH_CR) begin
        // held back until we know whether an LF follows
        mode_next       = f1.mode;
        acc_next        = f1.acc;
        line_len_next   = f1.len;
        digit_seen_next = f1.digit;
        pending_cr_next = 1'b1;
      end else begin
        mode_next       = f2.mode;
        acc_next        = f2.acc;
        line_len_next   = f2.len;
        digit_seen_next = f2.digit;
        pending_cr_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SIZE;
      remaining  <= '0;
      acc        <= '0;
      line_len   <= '0;
      digit_seen <= 1'b0;
      pending_cr <= 1'b0;
      err_code   <= 2'd0;
    end else begin
      mode       <= mode_next;
      remaining  <= remaining_next;
      acc        <= acc_next;
      line_len   <= line_len_next;
      digit_seen <= digit_seen_next;
      pending_cr <= pending_cr_next;
      err_code   <= err_code_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/hcbd_out_reg.sv
// result register of the chunked body deframer with downstream stall handling
`default_nettype none

module hcbd_out_reg
  import hcbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire result_t    res,
  output logic            advance,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      result_kind,
  output logic [7:0]      data_byte,
  output logic [1:0]      error_code
);

  // the register can take a new result when empty or being drained
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      result_kind <= res.kind;
      data_byte   <= res.data;
      error_code  <= res.code;
    end
  end

endmodule

`default_nettype wire

>>> sv/http_chunked_body_deframer.sv
// top level of the chunked body deframer
`default_nettype none

// Strips HTTP/1.1 chunked framing from a body byte stream. Each accepted byte
// yields at most one result: a payload byte, a message-finished mark or a
// sticky error. One byte is accepted every cycle while in_stall is low; a
// byte sits in the input register, its result in the result register, as the
// whole per-byte parse is one combinational step between the two. Stall on
// the result side holds both registers. max_line_length is written through the
// cfg channel, which is always ready, and should only change while idle.
module http_chunked_body_deframer
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_stream,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               result_kind,
  output logic [7:0]               data_byte,
  output logic [1:0]               error_code,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [LEN_BITS-1:0] cfg_data
);

  logic [LEN_BITS-1:0] max_line_length;
  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_eos;
  logic                advance;
  logic                step;
  result_t             res;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid && !advance;
  assign step      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= MAX_LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_line_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
      s1_eos  <= end_of_stream;
    end
  end

  hcbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .in_byte         (s1_byte),
    .end_of_stream   (s1_eos),
    .max_line_length (max_line_length),
    .res             (res)
  );

  hcbd_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .data_byte   (data_byte),
    .error_code  (error_code)
  );

endmodule

`default_nettype wire
